/* hdl/lcg_rejection_gaussian_sampler_unit_defines.svh */
// Assertion macros shared by the checker of the sampler unit.
`ifndef LCG_REJECTION_GAUSSIAN_SAMPLER_UNIT_DEFINES_SVH
`define LCG_REJECTION_GAUSSIAN_SAMPLER_UNIT_DEFINES_SVH

// Check a property on every edge outside reset.
`define LRGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define LRGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/lrgs_pkg.sv */
// Package of the sampler unit: constants, shared types and the acceptance table.
package lrgs_pkg;

  localparam int TABLE_DEPTH = 1536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [47:0] LCG_INC = 48'd11;
  localparam logic [23:0] LCG_ML  = 24'hECE66D;   // low 24 bits of the multiplier
  localparam logic [10:0] LCG_MH  = 11'h5DE;      // high 11 bits of the multiplier
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] ACC_MAX = 64'hFFFFFF;

  localparam logic [1:0] CFG_CENTROID   = 2'd0;
  localparam logic [1:0] CFG_SPREAD     = 2'd1;
  localparam logic [1:0] CFG_START_SEED = 2'd2;

  typedef struct packed {
    logic signed [31:0] centroid;
    logic        [31:0] spread;
    logic        [47:0] start_seed;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic restart;
  } req_t;

  typedef logic [23:0] acc_tab_t [TABLE_DEPTH];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] exp_neg_q62(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q62_ONE;
    term = Q62_ONE;
    for (int k = 1; k <= 40; k++) begin
      if (term != 64'd0) begin
        term = mul_q62(term, f) / 64'(k);
        if (k % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic acc_tab_t build_tab();
    acc_tab_t    tab;
    logic [63:0] einv;
    logic [63:0] sq;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] v;
    einv = exp_neg_q62(Q62_ONE);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sq = 64'(i) * 64'(i);
      n  = sq >> 17;
      e  = exp_neg_q62((sq & 64'h1FFFF) << 45);
      while (n > 64'd0) begin
        e = mul_q62(e, einv);
        n = n - 64'd1;
      end
      v = e >> 38;
      tab[i] = (v > ACC_MAX) ? ACC_MAX[23:0] : v[23:0];
    end
    return tab;
  endfunction

  localparam acc_tab_t ACC_TAB = build_tab();

endpackage

/* hdl/lrgs_front.sv */
// Front end: accept requests and hold them in a two-entry queue.
module lrgs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_restart,
  output lrgs_pkg::req_t req,
  input  logic          req_pop
);
  import lrgs_pkg::*;

  logic       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall    = (cnt_r == 2'd2);
  assign push        = in_valid && !in_stall;
  assign req.valid   = (cnt_r != 2'd0);
  assign req.restart = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = req_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, req_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= in_restart;
  end

endmodule

/* hdl/lrgs_back.sv */
// Back end: draw uniform pairs, run the acceptance test, scale and deliver.
module lrgs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lrgs_pkg::cfg_t     cfg,
  input  lrgs_pkg::req_t     req,
  output logic               req_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sample,
  output logic        [15:0] out_uniforms_used
);
  import lrgs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]         st_r;
  logic [47:0]        lcg_r;
  logic [47:0]        p0_r;
  logic [23:0]        p1_r, p2_r;
  logic               second_r;
  logic [23:0]        r1_r;
  logic signed [28:0] u_r;
  logic [23:0]        thr_r;
  logic [15:0]        used_r;
  logic signed [61:0] prod_r;
  logic               out_valid_r;
  logic signed [31:0] out_sample_r;
  logic [15:0]        out_used_r;

  logic [47:0]        lcg_nxt;
  logic [23:0]        mid;
  logic [28:0]        r1x12;
  logic signed [28:0] u_c;
  logic [28:0]        mag;
  logic [12:0]        idx;
  logic signed [37:0] scaled;
  logic signed [38:0] total;
  logic signed [31:0] sat;
  logic               out_free;

  assign out_valid         = out_valid_r;
  assign out_sample        = out_sample_r;
  assign out_uniforms_used = out_used_r;
  assign out_free          = !out_valid_r || !out_stall;
  assign req_pop           = (st_r == ST_IDLE) && req.valid;

  always_comb begin
    mid     = p1_r + p2_r;
    lcg_nxt = p0_r + {mid, 24'd0} + LCG_INC;
    r1x12   = {5'd0, r1_r} * 29'd12;
    u_c     = $signed(r1x12) - $signed(29'(32'd6 << 24));
    mag     = u_c[28] ? 29'(-u_c) : u_c;
    idx     = mag[28:16];
    scaled  = 38'(prod_r >>> 24);
    total   = 39'(cfg.centroid) + 39'(scaled);
    if (total > 39'sd2147483647)       sat = 32'sh7FFFFFFF;
    else if (total < -39'sd2147483648) sat = 32'sh80000000;
    else                               sat = total[31:0];
  end

  // Table read is registered; the lookup uses the first draw of the pair.
  always_ff @(posedge clk) begin
    if (idx < 13'(TABLE_DEPTH)) thr_r <= ACC_TAB[ADDR_W'(idx)];
    else                        thr_r <= 24'd0;
    u_r <= u_c;
  end

  always_ff @(posedge clk) begin
    p0_r   <= {24'd0, lcg_r[23:0]} * {24'd0, LCG_ML};
    p1_r   <= 24'({13'd0, lcg_r[23:0]} * {26'd0, LCG_MH});
    p2_r   <= 24'(lcg_r[47:24] * LCG_ML);
    prod_r <= $signed({1'b0, cfg.spread}) * u_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      lcg_r       <= 48'd1;
      second_r    <= 1'b0;
      used_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise on a new result, hold while stalled, drop once taken.
      out_valid_r <= ((st_r == ST_OUT) && out_free) ? 1'b1 : (out_valid_r && out_stall);
      unique case (st_r)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.restart) lcg_r <= cfg.start_seed;
            used_r   <= 16'd0;
            second_r <= 1'b0;
            st_r     <= ST_MUL;
          end
        end
        ST_MUL: st_r <= ST_ADD;
        ST_ADD: begin
          lcg_r <= lcg_nxt;
          if (!second_r) begin
            r1_r     <= lcg_nxt[47:24];
            second_r <= 1'b1;
            st_r     <= ST_MUL;
          end else begin
            second_r <= 1'b0;
            used_r   <= (used_r >= 16'd65533) ? 16'hFFFF : used_r + 16'd2;
            st_r     <= (lcg_nxt[47:24] < thr_r) ? ST_SCALE : ST_MUL;
          end
        end
        ST_SCALE: st_r <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_sample_r <= sat;
            out_used_r   <= used_r;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/lcg_rejection_gaussian_sampler_unit.sv */
// Top level of the rejection-sampling Gaussian unit with a 48-bit LCG.
//
// Usage:
//   Input channel (in_valid / in_stall / in_restart): one transaction asks
//   for one sample; in_restart = 1 reloads the generator from start_seed.
//   Result channel (out_valid / out_stall): one transaction per request,
//   out_sample in signed Q16.16 (saturated) and out_uniforms_used.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//   centroid, 1 spread, 2 start_seed; other indexes are dropped. cfg_ready
//   is always high. Write only while the unit is idle.
// Flow:
//   Each uniform draw runs the LCG multiply-add: three partial products
//   in ST_MUL, then the sum in ST_ADD. A sample passes ST_IDLE, one draw
//   per uniform of each proposal pair (close to 4.8 pairs on average), then
//   ST_SCALE and ST_OUT; one request at a time is worked, while a two-entry
//   request queue and the output register keep both channels moving.
// Reset: generator state 1, centroid 0, spread 1.0, start_seed 1, queue empty.
// Stall: a result held by out_stall stays put; the back end waits with its
//   next result and the queue keeps accepting until full.
module lcg_rejection_gaussian_sampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sample,
  output logic        [15:0] out_uniforms_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [47:0] cfg_data
);
  import lrgs_pkg::*;

  cfg_t cfg_r;
  req_t req;
  logic req_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centroid   <= 32'sd0;
      cfg_r.spread     <= 32'd65536;
      cfg_r.start_seed <= 48'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTROID:   cfg_r.centroid   <= $signed(cfg_data[31:0]);
        CFG_SPREAD:     cfg_r.spread     <= cfg_data[31:0];
        CFG_START_SEED: cfg_r.start_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  lrgs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .req        (req),
    .req_pop    (req_pop)
  );

  lrgs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .req               (req),
    .req_pop           (req_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_uniforms_used (out_uniforms_used)
  );

endmodule

/* hdl/lrgs_checker.sv */
// Port-level checker of the sampler unit and its bind.
`include "lcg_rejection_gaussian_sampler_unit_defines.svh"

module lrgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_sample,
  input logic        [15:0] out_uniforms_used,
  input logic               cfg_ready
);

  `LRGS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_uniforms_used), "stalled result changed")
  `LRGS_ASSERT(a_used_form, out_valid |-> (out_uniforms_used != 16'd0) && (!out_uniforms_used[0] || out_uniforms_used == 16'hFFFF), "bad uniform count")
  `LRGS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result after reset")
  `LRGS_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind lcg_rejection_gaussian_sampler_unit lrgs_checker u_lrgs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sample        (out_sample),
  .out_uniforms_used (out_uniforms_used),
  .cfg_ready         (cfg_ready)
);

/* verif/tb_top.sv */
// Testbench for the rejection-sampling Gaussian unit: stimulus, prediction and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrgs_pkg::*;

  localparam int          ACC_DEPTH  = 1536;
  localparam logic [47:0] GEN_MULT   = 48'd25214903917;
  localparam logic [47:0] GEN_INC    = 48'd11;
  localparam logic [63:0] Q62_UNIT   = 64'd1 << 62;
  localparam int          DRAIN_CYC  = 40;      // tail after the last result
  localparam int          IDLE_LIMIT = 20000;   // cycles without any transaction

  // Own fixed-point product for the acceptance table: floor(a*b / 2^62).
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-f) in Q62 by an alternating Taylor series, f in [0, 1].
  function automatic logic [63:0] q62_exp_neg(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = Q62_UNIT;
    term = Q62_UNIT;
    for (int k = 1; k <= 40; k++) begin
      if (term != 0) begin
        term = q62_product(term, f) / 64'(k);
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
    end
    return acc;
  endfunction

  // Gaussian sampler predictor: generator state, registers and expected results.
  class gauss_scoreboard;
    logic [23:0]        accept_lut [ACC_DEPTH];
    logic [47:0]        gen_state;
    logic signed [31:0] mean;
    logic [31:0]        sigma;
    logic [47:0]        seed;
    logic signed [31:0] want_sample [$];
    logic [15:0]        want_used [$];
    int                 errors;

    function new();
      logic [63:0] einv, sq, e, v;
      einv = q62_exp_neg(Q62_UNIT);
      for (int i = 0; i < ACC_DEPTH; i++) begin
        sq = 64'(i) * 64'(i);
        e  = q62_exp_neg((sq & 64'h1FFFF) << 45);
        for (int n = 0; n < int'(sq >> 17); n++) e = q62_product(e, einv);
        v = e >> 38;
        accept_lut[i] = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
      end
      gen_state = 48'd1;
      mean      = 0;
      sigma     = 32'd65536;
      seed      = 48'd1;
      errors    = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [47:0] data);
      case (idx)
        CFG_CENTROID:   mean  = data[31:0];
        CFG_SPREAD:     sigma = data[31:0];
        CFG_START_SEED: seed  = data;
        default: ;
      endcase
    endfunction

    function logic [23:0] draw();
      gen_state = gen_state * GEN_MULT + GEN_INC;
      return gen_state[47:24];
    endfunction

    // Run the rejection loop for one accepted request and queue its result.
    function void note_request(input logic restart);
      logic [23:0]        r1, r2, thr;
      logic signed [63:0] u, mag, prod, total;
      logic [15:0]        used;
      used = 0;
      if (restart) gen_state = seed;
      forever begin
        r1   = draw();
        r2   = draw();
        used = (used >= 16'd65533) ? 16'hFFFF : used + 16'd2;
        u    = $signed(64'(r1) * 64'd12) - 64'sd100663296;
        mag  = (u < 0) ? -u : u;
        thr  = ((mag >>> 16) < ACC_DEPTH) ? accept_lut[mag >>> 16] : 24'd0;
        if (r2 < thr) break;
      end
      prod  = $signed({32'd0, sigma}) * u;
      total = 64'(mean) + (prod >>> 24);   // arithmetic shift floors
      if (total > 64'sd2147483647)  total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      want_sample.push_back(total[31:0]);
      want_used.push_back(used);
    endfunction

    function void check_result(input logic signed [31:0] sample, input logic [15:0] used);
      logic signed [31:0] es;
      logic [15:0]        eu;
      if (want_sample.size() == 0) begin
        $display("%0t: unexpected result sample=%0d used=%0d", $time, sample, used);
        errors++;
        return;
      end
      es = want_sample.pop_front();
      eu = want_used.pop_front();
      if (sample !== es) begin
        $display("%0t: sample mismatch expected %0d actual %0d", $time, es, sample);
        errors++;
      end
      if (used !== eu) begin
        $display("%0t: uniforms_used mismatch expected %0d actual %0d", $time, eu, used);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_sample;
  logic        [15:0] out_uniforms_used;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = CFG_CENTROID;
  logic        [47:0] cfg_data = '0;

  gauss_scoreboard sb = new();
  bit              calm = 1'b0;   // set for the last stretch: no idling on either side
  int              idle_cycles = 0;

  lcg_rejection_gaussian_sampler_unit dut (.*);

  always #6 clk = ~clk;

  // Result side: stall in random bursts, check every accepted transaction.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_sample, out_uniforms_used);
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: abort when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lcg_rejection_gaussian_sampler_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request; hold valid until accepted, then maybe idle a burst.
  task automatic send_request(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    sb.note_request(restart);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every result is back and the unit is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_sample.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Write one register; upper data bits carry noise the unit must ignore.
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  task automatic set_regs(input logic [47:0] c, input logic [47:0] s, input logic [47:0] seed);
    drain();
    write_reg(CFG_CENTROID, c);
    write_reg(CFG_SPREAD, s);
    write_reg(CFG_START_SEED, seed);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset values, then extreme seeds, spreads and centroids.
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    set_regs(48'd0, 48'd65536, 48'd0);              // zero seed still advances
    send_request(1'b1);
    send_request(1'b0);
    set_regs(48'd0, 48'd65536, 48'hFFFF_FFFF_FFFF);
    send_request(1'b1);
    send_request(1'b0);
    set_regs(48'hFFFF_7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd12345);  // saturate high side
    repeat (4) send_request(1'b0);
    set_regs(48'h0000_8000_0000, 48'hFFFF_FFFF, 48'd777);         // saturate low side
    repeat (4) send_request(1'b0);
    set_regs(48'h1234_7FFF_FFFF, 48'd0, 48'd99);                  // zero spread
    send_request(1'b1);
    send_request(1'b0);
    set_regs(48'h0000_8000_0000, 48'd1, 48'd5);
    send_request(1'b1);
    send_request(1'b1);

    // Random phases with a new register setting each.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(48'd0, 48'd65536, rand48());
        1: set_regs(rand48(), rand48(), rand48());
        2: set_regs(48'hFFFF_7FFF_FFFF, 48'hFFFF_FFFF, rand48());
        3: set_regs(48'h0000_8000_0000, 48'h8000_0000, rand48());
        4: set_regs(rand48(), {32'd0, 16'($urandom)}, rand48());
        default: set_regs(rand48(), rand48(), rand48());
      endcase
      if (ph == 6) calm = 1'b1;
      repeat (250) send_request($urandom_range(0, 9) == 0);
    end

    drain();
    if (sb.errors == 0) begin
      $display("lcg_rejection_gaussian_sampler_unit verification clean");
    end else begin
      $display("lcg_rejection_gaussian_sampler_unit verification failed");
    end
    $finish;
  end
endmodule

/* lcg_rejection_gaussian_sampler_unit.f */
+incdir+hdl
hdl/lrgs_pkg.sv
hdl/lrgs_front.sv
hdl/lrgs_back.sv
hdl/lcg_rejection_gaussian_sampler_unit.sv
hdl/lrgs_checker.sv
verif/tb_top.sv
